// ===== design/d2fx_pkg.sv =====
`default_nettype none
package d2fx_pkg;
   localparam int MaxTotalBits = 63;
   localparam int WBits = $clog2(MaxTotalBits + 1);

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_SAT_HIGH = 3'd1,
      ST_SAT_LOW  = 3'd2,
      ST_NEG_CLIP = 3'd3,
      ST_INVALID  = 3'd4
   } status_type;

   // Stage 1 to stage 2: decoded operand and shift amount.
   typedef struct packed {
      logic         valid;
      logic         invalid;
      logic         neg;
      logic         nonzero;
      logic         is_inf;
      logic         sgn_mode;
      logic [5:0]   w;
      logic [52:0]  mag;
      logic signed [12:0] es;
   } dec_type;

   // Stage 2 to stage 3: rounded magnitude.
   typedef struct packed {
      logic         valid;
      logic         invalid;
      logic         neg;
      logic         nonzero;
      logic         sgn_mode;
      logic [5:0]   w;
      logic         big;
      logic [63:0]  r;
   } rnd_type;
endpackage
`default_nettype wire

// ===== design/d2fx_decode.sv =====
`default_nettype none
module d2fx_decode (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [63:0]       value_bits,
   input  wire logic              signed_mode,
   input  wire logic signed [6:0] int_bits,
   input  wire logic signed [6:0] frac_bits,
   output d2fx_pkg::dec_type      dec_out
);
   d2fx_pkg::dec_type dec_ff, dec_in;
   logic signed [7:0] w_full;
   logic [10:0] ex;
   logic [51:0] man;

   always_comb begin
      w_full = 8'(int_bits) + 8'(frac_bits);
      ex = value_bits[62:52];
      man = value_bits[51:0];
      dec_in.valid = in_valid;
      dec_in.invalid = (w_full < 8'sd1) || (w_full > 8'(d2fx_pkg::MaxTotalBits)) ||
                       (ex == 11'h7FF && man != 52'd0);
      dec_in.neg = value_bits[63];
      dec_in.nonzero = (ex != 11'd0) || (man != 52'd0);
      dec_in.is_inf = (ex == 11'h7FF);
      dec_in.sgn_mode = signed_mode;
      dec_in.w = w_full[5:0];
      if (ex == 11'd0) begin
         dec_in.mag = {1'b0, man};
         dec_in.es = -13'sd1074 + 13'(frac_bits);
      end else begin
         dec_in.mag = {1'b1, man};
         dec_in.es = 13'($signed({2'b00, ex})) - 13'sd1075 + 13'(frac_bits);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff.valid <= 1'b0;
      end else begin
         dec_ff.valid <= dec_in.valid;
      end
      dec_ff.invalid <= dec_in.invalid;
      dec_ff.neg <= dec_in.neg;
      dec_ff.nonzero <= dec_in.nonzero;
      dec_ff.is_inf <= dec_in.is_inf;
      dec_ff.sgn_mode <= dec_in.sgn_mode;
      dec_ff.w <= dec_in.w;
      dec_ff.mag <= dec_in.mag;
      dec_ff.es <= dec_in.es;
   end

   assign dec_out = dec_ff;
endmodule
`default_nettype wire

// ===== design/d2fx_round.sv =====
`default_nettype none
module d2fx_round (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire d2fx_pkg::dec_type dec_in,
   output d2fx_pkg::rnd_type rnd_out
);
   d2fx_pkg::rnd_type rnd_ff, rnd_in;
   logic [5:0]  sh;
   logic [63:0] mag64, q, rem, half, shl;
   logic        left_big;

   always_comb begin
      mag64 = {11'd0, dec_in.mag};
      sh = 6'd0;
      q = 64'd0;
      rem = 64'd0;
      half = 64'd0;
      shl = 64'd0;
      left_big = 1'b0;
      rnd_in.valid = dec_in.valid;
      rnd_in.invalid = dec_in.invalid;
      rnd_in.neg = dec_in.neg;
      rnd_in.nonzero = dec_in.nonzero;
      rnd_in.sgn_mode = dec_in.sgn_mode;
      rnd_in.w = dec_in.w;
      rnd_in.big = 1'b0;
      rnd_in.r = 64'd0;
      if (dec_in.is_inf) begin
         rnd_in.big = 1'b1;
      end else if (dec_in.mag == 53'd0) begin
         rnd_in.r = 64'd0;
      end else if (dec_in.es >= 13'sd0) begin
         if (dec_in.es > 13'sd63) begin
            rnd_in.big = 1'b1;
         end else begin
            sh = dec_in.es[5:0];
            shl = mag64 << sh;
            left_big = ((shl >> sh) != mag64);
            rnd_in.big = left_big;
            rnd_in.r = shl;
         end
      end else if (dec_in.es > -13'sd64) begin
         sh = 6'(-dec_in.es);
         q = mag64 >> sh;
         rem = mag64 & ((64'd1 << sh) - 64'd1);
         half = 64'd1 << (sh - 6'd1);
         rnd_in.r = q + 64'((rem > half) || (rem == half && q[0]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_ff.valid <= 1'b0;
      end else begin
         rnd_ff.valid <= rnd_in.valid;
      end
      rnd_ff.invalid <= rnd_in.invalid;
      rnd_ff.neg <= rnd_in.neg;
      rnd_ff.nonzero <= rnd_in.nonzero;
      rnd_ff.sgn_mode <= rnd_in.sgn_mode;
      rnd_ff.w <= rnd_in.w;
      rnd_ff.big <= rnd_in.big;
      rnd_ff.r <= rnd_in.r;
   end

   assign rnd_out = rnd_ff;
endmodule
`default_nettype wire

// ===== design/d2fx_clamp.sv =====
`default_nettype none
module d2fx_clamp (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire d2fx_pkg::rnd_type rnd_in,
   output logic              out_valid,
   output logic [62:0]       out_fixed,
   output logic [2:0]        out_status
);
   logic        valid_ff;
   logic [62:0] fixed_ff, fixed_in;
   d2fx_pkg::status_type st_ff, st_in;
   logic [63:0] mask, lim, f;

   always_comb begin
      mask = (64'd1 << rnd_in.w) - 64'd1;
      lim = 64'd1 << (rnd_in.w - 6'd1);
      f = 64'd0;
      st_in = d2fx_pkg::ST_OK;
      if (rnd_in.invalid) begin
         st_in = d2fx_pkg::ST_INVALID;
      end else if (rnd_in.sgn_mode) begin
         if (rnd_in.neg) begin
            if (rnd_in.big || rnd_in.r > lim) begin
               f = (64'd0 - lim) & mask;
               st_in = d2fx_pkg::ST_SAT_LOW;
            end else begin
               f = (64'd0 - rnd_in.r) & mask;
            end
         end else if (rnd_in.big || rnd_in.r > lim - 64'd1) begin
            f = lim - 64'd1;
            st_in = d2fx_pkg::ST_SAT_HIGH;
         end else begin
            f = rnd_in.r;
         end
      end else if (rnd_in.neg && rnd_in.nonzero) begin
         st_in = d2fx_pkg::ST_NEG_CLIP;
      end else if (rnd_in.big || rnd_in.r > mask) begin
         f = mask;
         st_in = d2fx_pkg::ST_SAT_HIGH;
      end else begin
         f = rnd_in.r;
      end
      fixed_in = f[62:0] & mask[62:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= rnd_in.valid;
      end
      fixed_ff <= fixed_in;
      st_ff <= st_in;
   end

   assign out_valid = valid_ff;
   assign out_fixed = fixed_ff;
   assign out_status = st_ff;

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rnd_in.valid && rnd_in.invalid) |=> (out_fixed == 63'd0))
      else $error("invalid beat gave nonzero value");
   a_clip_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_status == d2fx_pkg::ST_NEG_CLIP |-> out_fixed == 63'd0)
      else $error("clipped beat gave nonzero value");
   a_valid_follow: assert property (@(posedge clock) disable iff (reset)
      rnd_in.valid |=> out_valid)
      else $error("beat lost in clamp stage");
endmodule
`default_nettype wire

// ===== design/double_to_fixed_saturating.sv =====
`default_nettype none
// Converts an IEEE-754 double to a saturating fixed-point value, one beat per
// clock. busy is always low, so a beat may be started every cycle; each result
// passes the decode, round and clamp registers onto the rsp_ ports, marked by
// rsp_valid for one cycle. The three stages are decode, shift and round, and
// clamp. The receiver cannot stall the pipeline and must take every result.
module double_to_fixed_saturating (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [63:0]       req_value_bits,
   input  wire logic              req_signed_mode,
   input  wire logic signed [6:0] req_int_bits,
   input  wire logic signed [6:0] req_frac_bits,
   output logic                   rsp_valid,
   output logic [62:0]            rsp_fixed_value,
   output logic [2:0]             rsp_status
);
   d2fx_pkg::dec_type dec;
   d2fx_pkg::rnd_type rnd;

   assign busy = 1'b0;

   d2fx_decode u_decode (
      .clock(clock), .reset(reset), .in_valid(start && !busy),
      .value_bits(req_value_bits), .signed_mode(req_signed_mode),
      .int_bits(req_int_bits), .frac_bits(req_frac_bits), .dec_out(dec)
   );

   d2fx_round u_round (.clock(clock), .reset(reset), .dec_in(dec), .rnd_out(rnd));

   d2fx_clamp u_clamp (
      .clock(clock), .reset(reset), .rnd_in(rnd), .out_valid(rsp_valid),
      .out_fixed(rsp_fixed_value), .out_status(rsp_status)
   );
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`default_nettype none
module testbench;
   typedef struct {
      logic [63:0]       value_bits;
      logic              signed_mode;
      logic signed [6:0] int_bits;
      logic signed [6:0] frac_bits;
   } conv_req_type;

   typedef struct {
      logic [62:0]          fixed_value;
      d2fx_pkg::status_type status;
   } conv_rsp_type;

   localparam int StallLimit = 2000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [63:0]       req_value_bits = '0;
   logic              req_signed_mode = 1'b0;
   logic signed [6:0] req_int_bits = '0;
   logic signed [6:0] req_frac_bits = '0;
   logic              rsp_valid;
   logic [62:0]       rsp_fixed_value;
   logic [2:0]        rsp_status;

   conv_req_type pending_reqs[$];
   conv_rsp_type expected_rsps[$];
   int        error_count = 0;
   int        idle_cycles = 0;
   int        quiet_from = 0;
   int        gap_left = 0;
   int        sent_count = 0;
   int        stall_count = 0;
   bit        stim_done = 1'b0;

   double_to_fixed_saturating dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_value_bits(req_value_bits), .req_signed_mode(req_signed_mode),
      .req_int_bits(req_int_bits), .req_frac_bits(req_frac_bits),
      .rsp_valid(rsp_valid), .rsp_fixed_value(rsp_fixed_value),
      .rsp_status(rsp_status)
   );

   always #1 clock = ~clock;

   // Round mag * 2^es to nearest with ties to even; too_big flags >= 2^64.
   function automatic logic [63:0] round_scaled(input logic [63:0] mag, input int es,
                                                output bit too_big);
      logic [63:0] q, rem, half;
      int sh;
      too_big = 1'b0;
      if (mag == 0) return 64'd0;
      if (es >= 0) begin
         if (es > 63 || mag > ({64{1'b1}} >> es)) begin
            too_big = 1'b1;
            return 64'd0;
         end
         return mag << es;
      end
      sh = -es;
      if (sh >= 64) return 64'd0;
      q = mag >> sh;
      rem = mag & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      return q;
   endfunction

   function automatic conv_rsp_type convert_double(input conv_req_type rq);
      conv_rsp_type         res;
      int                   w, fb, ex;
      logic [51:0]          man;
      logic [63:0]          mask, r, lim, fixed;
      bit                   neg, big, nonzero;
      d2fx_pkg::status_type st;
      fb = int'(rq.frac_bits);
      w = int'(rq.int_bits) + fb;
      neg = rq.value_bits[63];
      ex = int'(rq.value_bits[62:52]);
      man = rq.value_bits[51:0];
      nonzero = (ex != 0 || man != 0);
      big = 1'b0;
      r = '0;
      st = d2fx_pkg::ST_OK;
      if (w < 1 || w > d2fx_pkg::MaxTotalBits || (ex == 2047 && man != 0)) begin
         res.fixed_value = '0;
         res.status = d2fx_pkg::ST_INVALID;
         return res;
      end
      mask = (64'd1 << w) - 64'd1;
      if (ex == 2047) big = 1'b1;
      else if (ex == 0) r = round_scaled({12'd0, man}, -1074 + fb, big);
      else r = round_scaled({11'd0, 1'b1, man}, ex - 1075 + fb, big);
      if (rq.signed_mode) begin
         lim = 64'd1 << (w - 1);
         if (neg) begin
            if (big || r > lim) begin
               fixed = (64'd0 - lim) & mask;
               st = d2fx_pkg::ST_SAT_LOW;
            end else begin
               fixed = (64'd0 - r) & mask;
            end
         end else if (big || r > lim - 64'd1) begin
            fixed = lim - 64'd1;
            st = d2fx_pkg::ST_SAT_HIGH;
         end else begin
            fixed = r;
         end
      end else if (neg && nonzero) begin
         fixed = '0;
         st = d2fx_pkg::ST_NEG_CLIP;
      end else if (big || r > mask) begin
         fixed = mask;
         st = d2fx_pkg::ST_SAT_HIGH;
      end else begin
         fixed = r;
      end
      fixed = fixed & mask;
      res.fixed_value = fixed[62:0];
      res.status = st;
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic add_conv(input logic [63:0] v, input logic sm, input int ib, input int fb);
      conv_req_type rq;
      rq.value_bits = v;
      rq.signed_mode = sm;
      rq.int_bits = ib[6:0];
      rq.frac_bits = fb[6:0];
      pending_reqs.push_back(rq);
   endtask

   // Half the picks are values near the scale of the format, so rounding and saturation get hit.
   function automatic logic [63:0] pick_double(input int ib, input int fb);
      logic [63:0] v;
      int e;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: ;
         1: v[62:52] = 11'h7FF;
         2: v[62:52] = 11'd0;
         3: v[62:0] = '0;
         4: v[51:0] = {1'b1, 51'd0} >> $urandom_range(0, 51);
         default: begin
            e = 1023 + $urandom_range(0, 4) - fb + $urandom_range(0, 70) - 6 - 1;
            if (ib > 0) e = e + $urandom_range(0, ib);
            if (e < 1) e = 1;
            if (e > 2046) e = 2046;
            v[62:52] = e[10:0];
            if ($urandom_range(0, 2) == 0) v[51:0] = v[51:0] & ({52{1'b1}} << $urandom_range(0, 52));
         end
      endcase
      return v;
   endfunction

   initial begin
      int ib, fb;
      // Directed: zero, minus zero, infinities, NaN, denormals, ties, width bounds.
      add_conv(64'h0000_0000_0000_0000, 1'b1, 8, 8);
      add_conv(64'h8000_0000_0000_0000, 1'b0, 8, 8);
      add_conv(64'h7FF0_0000_0000_0000, 1'b1, 16, 0);
      add_conv(64'hFFF0_0000_0000_0000, 1'b1, 16, 0);
      add_conv(64'hFFF0_0000_0000_0000, 1'b0, 16, 0);
      add_conv(64'h7FF8_0000_0000_0001, 1'b1, 8, 8);
      add_conv(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8, 8);
      add_conv(64'h0000_0000_0000_0001, 1'b0, -32, 63);
      add_conv(64'h800F_FFFF_FFFF_FFFF, 1'b0, 1, 0);
      add_conv(64'h3FE0_0000_0000_0000, 1'b1, 4, 0);
      add_conv(64'h3FF8_0000_0000_0000, 1'b1, 4, 0);
      add_conv(64'hC004_0000_0000_0000, 1'b1, 4, 0);
      add_conv(64'h3FF0_0000_0000_0000, 1'b1, 63, 0);
      add_conv(64'h3FF0_0000_0000_0000, 1'b1, 63, 1);
      add_conv(64'h3FF0_0000_0000_0000, 1'b0, -32, 32);
      add_conv(64'h3FF0_0000_0000_0000, 1'b0, 0, 0);
      add_conv(64'h3FF0_0000_0000_0000, 1'b0, 63, 63);
      add_conv(64'h43E0_0000_0000_0000, 1'b1, 63, -32);
      add_conv(64'hC3E0_0000_0000_0000, 1'b1, 32, 31);
      add_conv(64'h7FEF_FFFF_FFFF_FFFF, 1'b0, 63, -1);
      add_conv(64'hBCB0_0000_0000_0000, 1'b0, 10, 10);
      add_conv(64'hC000_0000_0000_0000, 1'b1, 2, 0);
      add_conv(64'hC008_0000_0000_0000, 1'b1, 2, 0);
      add_conv(64'h4050_0000_0000_0000, 1'b1, 40, -32);
      for (int i = 0; i < 1000; i++) begin
         if ($urandom_range(0, 19) == 0) begin
            ib = $urandom_range(0, 95) - 32;
            fb = $urandom_range(0, 95) - 32;
         end else begin
            ib = $urandom_range(0, 95) - 32;
            fb = $urandom_range(1, 63) - ib;
            if (fb < -32) fb = -32;
            if (fb > 63) fb = 63;
         end
         add_conv(pick_double(ib, fb), $urandom_range(0, 1), ib, fb);
      end
      quiet_from = pending_reqs.size() - 150;
   end

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) sent_count++;
         if (start && busy) begin
            // Hold the beat until it is taken.
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_reqs.size() > 0 && sent_count < quiet_from
                      && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(0, 14);
            start <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            conv_req_type rq;
            rq = pending_reqs.pop_front();
            expected_rsps.push_back(convert_double(rq));
            req_value_bits <= rq.value_bits;
            req_signed_mode <= rq.signed_mode;
            req_int_bits <= rq.int_bits;
            req_frac_bits <= rq.frac_bits;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
            stim_done = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         conv_rsp_type exp_rsp;
         if (expected_rsps.size() == 0) begin
            report_mismatch("result beat with nothing expected");
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (rsp_fixed_value !== exp_rsp.fixed_value)
               report_mismatch($sformatf("fixed_value %h, expected %h",
                                         rsp_fixed_value, exp_rsp.fixed_value));
            if (rsp_status !== exp_rsp.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_status, exp_rsp.status));
         end
      end
   end

   // Watchdog: cycles with neither a start nor a result beat accepted.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) stall_count <= 0;
      else stall_count <= stall_count + 1;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      while (!(stim_done && expected_rsps.size() == 0) && stall_count < StallLimit)
         @(posedge clock);
      if (stall_count >= StallLimit) begin
         $display("Testbench completed WITH ERRORS");
      end else begin
         repeat (10) @(posedge clock);
         if (error_count == 0) $display("Testbench completed without errors");
         else $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
`default_nettype wire
